// ===== src/manchester_segment_transmitter_top_assert.svh =====
// Assertion macros for the segment transmitter.
// Each use stands on a line of its own after the logic it checks.
`ifndef MANCHESTER_SEGMENT_TRANSMITTER_TOP_ASSERT_SVH
`define MANCHESTER_SEGMENT_TRANSMITTER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define MST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mst_pkg.sv =====
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types and constants of the Manchester segment transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package mst_pkg;

    localparam int NumRegs = 8;
    localparam int RegW    = 16;
    localparam int CfgIdxW = 3;

    // Register indexes
    localparam logic [CfgIdxW-1:0] REG_MARK      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SPACE     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_PAD       = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_PRE       = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SYNC_HIGH = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SYNC_GAP  = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_TAIL_LOW  = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_TAIL_HIGH = 3'd7;

    // Operation codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic            line_level;
        logic [RegW-1:0] duration;
        logic            last;
    } out_t;

    // Duration request from the sequencer to the timing register file
    typedef struct packed {
        logic               hold;
        logic [CfgIdxW-1:0] sel;
    } seg_req_t;

    function automatic logic [RegW-1:0] reg_reset_val(input logic [CfgIdxW-1:0] idx);
        logic [RegW-1:0] v;
        case (idx)
            REG_MARK:      v = 16'd50;
            REG_SPACE:     v = 16'd110;
            REG_PAD:       v = 16'd100;
            REG_PRE:       v = 16'd66;
            REG_SYNC_HIGH: v = 16'd2000;
            REG_SYNC_GAP:  v = 16'd400;
            REG_TAIL_LOW:  v = 16'd120;
            REG_TAIL_HIGH: v = 16'd60;
            default:       v = 16'd1;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/mst_regs.sv =====
// ----------------------------------------------------------------------------
// mst_regs
// Timing register file with one read port that yields the segment duration.
// ----------------------------------------------------------------------------
`default_nettype none

module mst_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [mst_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [mst_pkg::RegW-1:0]     cfg_data,
    input  wire mst_pkg::seg_req_t            req,
    output logic      [mst_pkg::RegW-1:0]     duration
);

    logic [mst_pkg::RegW-1:0] regs_reg [mst_pkg::NumRegs];
    logic [mst_pkg::RegW-1:0] picked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mst_pkg::NumRegs; i++)
            begin
                regs_reg[i] <= mst_pkg::reg_reset_val(mst_pkg::CfgIdxW'(i));
            end
        end
        else if (cfg_we)
        begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    // A zero count reads as one so a timed segment never turns into a hold
    always_comb
    begin
        picked = regs_reg[req.sel];
        if (req.hold)
            duration = '0;
        else if (picked == '0)
            duration = mst_pkg::RegW'(1);
        else
            duration = picked;
    end

endmodule

`default_nettype wire

// ===== src/manchester_segment_transmitter_top.sv =====
// ----------------------------------------------------------------------------
// manchester_segment_transmitter_top
// Turns start, data byte and stop commands into timed line segments.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one command per beat.
//   Output channel out_valid/out_stall/out_data carries one segment per beat
//   (level, duration in delay units, last on the final segment of a command).
//   The block takes one command, then holds in_stall high while its sequencer
//   walks the segments, one segment per cycle into the output register.
//   Start gives 11 segments, a data byte 16 to 24, stop 2 or 3; unused
//   operation code 3 gives none. The first segment reaches out_valid through
//   the sequencer state register and then the output register; the input
//   stays stalled until the sequencer has emitted the last segment of a
//   command. The sequencer advances only when the output register is free
//   or being taken, so a stalled receiver freezes the sequence with no loss.
//   Timing registers are written through cfg_we/cfg_index/cfg_data; the user
//   must write them only while idle; the block itself does not enforce it.
//   Reset loads the default timing counts, drops the line level to low and
//   empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module manchester_segment_transmitter_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire mst_pkg::in_t                 in_data,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output mst_pkg::out_t                     out_data,
    input  wire logic                         cfg_we,
    input  wire logic [mst_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [mst_pkg::RegW-1:0]     cfg_data
);

    `include "manchester_segment_transmitter_top_assert.svh"

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_DATA  = 2'd2;
    localparam logic [1:0] ST_STOP  = 2'd3;

    localparam logic [3:0] START_LAST = 4'd10;

    localparam logic [1:0] PH_PAD    = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic [2:0]  bit_reg, bit_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  byte_reg, byte_next;
    logic        lvl_reg, lvl_next;
    logic        out_valid_reg, out_valid_next;
    mst_pkg::out_t out_reg, out_next;

    logic                     in_fire;
    logic                     out_fire;
    logic                     emit;
    logic                     bit_val;
    logic                     seg_level;
    logic                     seg_last;
    mst_pkg::seg_req_t        seg_req;
    logic [mst_pkg::RegW-1:0] seg_duration;

    mst_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (seg_req),
        .duration  (seg_duration)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_fire  = out_valid_reg && !out_stall;
    assign emit      = (state_reg != ST_IDLE) && (!out_valid_reg || !out_stall);
    assign bit_val   = byte_reg[bit_reg];

    // Sequencer: pick the segment for this cycle and advance
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        bit_next     = bit_reg;
        phase_next   = phase_reg;
        byte_next    = byte_reg;
        seg_level    = 1'b0;
        seg_last     = 1'b0;
        seg_req.hold = 1'b0;
        seg_req.sel  = mst_pkg::REG_MARK;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    step_next  = '0;
                    bit_next   = '0;
                    phase_next = PH_PAD;
                    byte_next  = in_data.data_byte;
                    case (in_data.operation)
                        mst_pkg::OP_START: state_next = ST_START;
                        mst_pkg::OP_DATA:  state_next = ST_DATA;
                        mst_pkg::OP_STOP:  state_next = ST_STOP;
                        default:           state_next = ST_IDLE;
                    endcase
                end
            end
            ST_START:
            begin
                case (step_reg)
                    4'd6:
                    begin
                        seg_level   = 1'b1;
                        seg_req.sel = mst_pkg::REG_SYNC_HIGH;
                    end
                    4'd7:
                    begin
                        seg_level   = 1'b0;
                        seg_req.sel = mst_pkg::REG_SYNC_GAP;
                    end
                    4'd8:
                    begin
                        seg_level   = 1'b1;
                        seg_req.sel = mst_pkg::REG_SYNC_GAP;
                    end
                    4'd9:
                    begin
                        seg_level   = 1'b0;
                        seg_req.sel = mst_pkg::REG_TAIL_LOW;
                    end
                    START_LAST:
                    begin
                        seg_level   = 1'b1;
                        seg_req.sel = mst_pkg::REG_TAIL_HIGH;
                        seg_last    = 1'b1;
                    end
                    default:
                    begin
                        // preamble: high on even steps, low on odd
                        seg_level   = !step_reg[0];
                        seg_req.sel = mst_pkg::REG_PRE;
                    end
                endcase
                if (emit)
                begin
                    step_next = step_reg + 4'd1;
                    if (seg_last)
                        state_next = ST_IDLE;
                end
            end
            ST_DATA:
            begin
                seg_level = bit_val;
                case (phase_reg)
                    PH_PAD:
                    begin
                        if (lvl_reg == bit_val)
                        begin
                            seg_req.sel = mst_pkg::REG_PAD;
                            if (emit)
                                phase_next = PH_FIRST;
                        end
                        else
                        begin
                            seg_req.sel = bit_val ? mst_pkg::REG_MARK : mst_pkg::REG_SPACE;
                            if (emit)
                                phase_next = PH_SECOND;
                        end
                    end
                    PH_FIRST:
                    begin
                        seg_req.sel = bit_val ? mst_pkg::REG_MARK : mst_pkg::REG_SPACE;
                        if (emit)
                            phase_next = PH_SECOND;
                    end
                    default:
                    begin
                        seg_level   = !bit_val;
                        seg_req.sel = bit_val ? mst_pkg::REG_SPACE : mst_pkg::REG_MARK;
                        seg_last    = (bit_reg == 3'd7);
                        if (emit)
                        begin
                            phase_next = PH_PAD;
                            bit_next   = bit_reg + 3'd1;
                            if (seg_last)
                                state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            default:
            begin
                // stop: from low a mark, from high space then mark, then held low
                case (step_reg)
                    4'd0:
                    begin
                        if (!lvl_reg)
                        begin
                            seg_level   = 1'b1;
                            seg_req.sel = mst_pkg::REG_MARK;
                            if (emit)
                                step_next = 4'd2;
                        end
                        else
                        begin
                            seg_level   = 1'b0;
                            seg_req.sel = mst_pkg::REG_SPACE;
                            if (emit)
                                step_next = 4'd1;
                        end
                    end
                    4'd1:
                    begin
                        seg_level   = 1'b1;
                        seg_req.sel = mst_pkg::REG_MARK;
                        if (emit)
                            step_next = 4'd2;
                    end
                    default:
                    begin
                        seg_level    = 1'b0;
                        seg_req.hold = 1'b1;
                        seg_last     = 1'b1;
                        if (emit)
                            state_next = ST_IDLE;
                    end
                endcase
            end
        endcase
    end

    // Output register and line level
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        lvl_next       = lvl_reg;
        if (out_fire)
            out_valid_next = 1'b0;
        if (emit)
        begin
            out_valid_next      = 1'b1;
            out_next.line_level = seg_level;
            out_next.duration   = seg_duration;
            out_next.last       = seg_last;
            lvl_next            = seg_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            bit_reg       <= '0;
            phase_reg     <= PH_PAD;
            lvl_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            bit_reg       <= bit_next;
            phase_reg     <= phase_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        out_reg  <= out_next;
    end

    `MST_ASSERT(a_hold_is_last, out_valid_reg && (out_reg.duration == '0) |-> out_reg.last, "hold segment without last")
    `MST_ASSERT(a_last_ends_cmd, emit && seg_last |=> (state_reg == ST_IDLE), "sequencer busy after last segment")
    `MST_ASSERT(a_start_leaves_high, emit && seg_last && (state_reg == ST_START) |=> lvl_reg, "start did not leave line high")
    `MST_ASSERT_ALWAYS(a_stop_leaves_low, rst_n && emit && seg_last && (state_reg == ST_STOP) |=> !lvl_reg, "stop did not leave line low")

endmodule

`default_nettype wire

// ===== tb/sv/manchester_segment_transmitter_top_test.sv =====
// ----------------------------------------------------------------------------
// manchester_segment_transmitter_top_test
// Self-checking bench for the segment transmitter: drives start, data byte,
// stop and unused commands under random idling on both channels, predicts
// every line segment from its own copy of the line level and timing
// registers, and compares each output beat field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module manchester_segment_transmitter_top_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         StallLimit = 2000;
    localparam int         SettleCycles = 8;
    localparam int         TailCycles = 30;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         in_valid = 1'b0;
    logic                         in_stall;
    mst_pkg::in_t                 in_data = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    mst_pkg::out_t                out_data;
    logic                         cfg_we = 1'b0;
    logic [mst_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [mst_pkg::RegW-1:0]     cfg_data = '0;

    // Bench copy of the block's state
    logic [mst_pkg::RegW-1:0] timing_regs [mst_pkg::NumRegs];
    logic                     line_now;
    mst_pkg::out_t            pending_segments [$];

    bit quiet = 1'b0;
    int error_count = 0;
    int segments_checked = 0;
    int random_settings = 0;
    int cmd_count [4];
    int idle_cycles = 0;

    manchester_segment_transmitter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // A register holding zero times out as one unit
    function automatic logic [mst_pkg::RegW-1:0] units(input logic [mst_pkg::CfgIdxW-1:0] sel);
        return (timing_regs[sel] == '0) ? mst_pkg::RegW'(1) : timing_regs[sel];
    endfunction

    function automatic void add_segment(input logic lvl, input logic [mst_pkg::RegW-1:0] dur);
        mst_pkg::out_t seg;
        seg.line_level = lvl;
        seg.duration   = dur;
        seg.last       = 1'b0;
        pending_segments.push_back(seg);
        line_now = lvl;
    endfunction

    function automatic void predict_segments(input mst_pkg::in_t cmd);
        int            first;
        mst_pkg::out_t tail;
        first = pending_segments.size();
        cmd_count[cmd.operation]++;
        case (cmd.operation)
            mst_pkg::OP_START:
            begin
                repeat (3)
                begin
                    add_segment(1'b1, units(mst_pkg::REG_PRE));
                    add_segment(1'b0, units(mst_pkg::REG_PRE));
                end
                add_segment(1'b1, units(mst_pkg::REG_SYNC_HIGH));
                add_segment(1'b0, units(mst_pkg::REG_SYNC_GAP));
                add_segment(1'b1, units(mst_pkg::REG_SYNC_GAP));
                add_segment(1'b0, units(mst_pkg::REG_TAIL_LOW));
                add_segment(1'b1, units(mst_pkg::REG_TAIL_HIGH));
            end
            mst_pkg::OP_DATA:
            begin
                // LSB first; pad when the line already sits at the first level
                for (int b = 0; b < 8; b++)
                begin
                    if (cmd.data_byte[b])
                    begin
                        if (line_now)
                            add_segment(1'b1, units(mst_pkg::REG_PAD));
                        add_segment(1'b1, units(mst_pkg::REG_MARK));
                        add_segment(1'b0, units(mst_pkg::REG_SPACE));
                    end
                    else
                    begin
                        if (!line_now)
                            add_segment(1'b0, units(mst_pkg::REG_PAD));
                        add_segment(1'b0, units(mst_pkg::REG_SPACE));
                        add_segment(1'b1, units(mst_pkg::REG_MARK));
                    end
                end
            end
            mst_pkg::OP_STOP:
            begin
                if (line_now)
                    add_segment(1'b0, units(mst_pkg::REG_SPACE));
                add_segment(1'b1, units(mst_pkg::REG_MARK));
                add_segment(1'b0, '0);
            end
            default: ;
        endcase
        if (pending_segments.size() > first)
        begin
            tail = pending_segments.pop_back();
            tail.last = 1'b1;
            pending_segments.push_back(tail);
        end
    endfunction

    // Predict on accepted commands, check accepted segments
    always @(posedge clk)
    begin : segment_scoreboard
        mst_pkg::out_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_segments(in_data);
            if (out_valid && !out_stall)
            begin
                if (pending_segments.size() == 0)
                begin
                    $display("%0t: unexpected segment level=%0d duration=%0d last=%0d",
                             $time, out_data.line_level, out_data.duration, out_data.last);
                    error_count++;
                end
                else
                begin
                    want = pending_segments.pop_front();
                    if (out_data.line_level !== want.line_level
                        || out_data.duration !== want.duration
                        || out_data.last !== want.last)
                    begin
                        $display("%0t: segment %0d expected level=%0d duration=%0d last=%0d,",
                                 $time, segments_checked, want.line_level, want.duration,
                                 want.last);
                        $display("%0t:   actual level=%0d duration=%0d last=%0d",
                                 $time, out_data.line_level, out_data.duration, out_data.last);
                        error_count++;
                    end
                    segments_checked++;
                end
            end
        end
    end

    // Drop the run when the channels sit still too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= StallLimit)
            begin
                $display("%0t: no beat for %0d cycles, %0d segments outstanding",
                         $time, StallLimit, pending_segments.size());
                $display("manchester_segment_transmitter_top: mismatch");
                $finish;
            end
        end
    end

    // Receiver back-pressure in random bursts
    initial
    begin : receiver_stalls
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_command(input logic [1:0] op, input logic [7:0] data_val);
        mst_pkg::in_t cmd;
        cmd.operation = op;
        cmd.data_byte = data_val;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        // hold the beat until the block takes it
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        // let the scoreboard see the last accepted command first
        @(posedge clk);
        while (pending_segments.size() != 0)
            @(posedge clk);
        // an unused command may still be in flight
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_timing(input logic [mst_pkg::CfgIdxW-1:0] idx,
                                input logic [mst_pkg::RegW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        timing_regs[idx] = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all_timing(input logic [mst_pkg::RegW-1:0] value);
        for (int i = 0; i < mst_pkg::NumRegs; i++)
            write_timing(mst_pkg::CfgIdxW'(i), value);
    endtask

    function automatic logic [mst_pkg::RegW-1:0] pick_units();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return mst_pkg::RegW'(1);
            2:       return '1;
            3:       return mst_pkg::RegW'($urandom_range(0, 65535));
            default: return mst_pkg::RegW'($urandom_range(2, 600));
        endcase
    endfunction

    // Mostly whole frames with random bytes, the rest noise and broken frames
    task automatic send_random_traffic(input int count);
        int sent;
        int nbytes;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6:
                begin
                    nbytes = $urandom_range(1, 6);
                    send_command(mst_pkg::OP_START, 8'($urandom_range(0, 255)));
                    repeat (nbytes) send_command(mst_pkg::OP_DATA, 8'($urandom_range(0, 255)));
                    send_command(mst_pkg::OP_STOP, 8'($urandom_range(0, 255)));
                    sent += nbytes + 2;
                end
                7, 8:
                begin
                    send_command(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                    if (in_data.operation != OP_UNUSED)
                        sent++;
                end
                default:
                begin
                    // frame missing its stop, and sometimes its start too
                    nbytes = $urandom_range(1, 3);
                    if ($urandom_range(0, 1))
                        send_command(mst_pkg::OP_START, 8'($urandom_range(0, 255)));
                    repeat (nbytes) send_command(mst_pkg::OP_DATA, 8'($urandom_range(0, 255)));
                    sent += nbytes + 1;
                end
            endcase
        end
    endtask

    task automatic test_default_timing();
        send_command(mst_pkg::OP_STOP, 8'h00);
        send_command(mst_pkg::OP_DATA, 8'h00);
        send_command(mst_pkg::OP_DATA, 8'hFF);
        send_command(mst_pkg::OP_START, 8'hFF);
        send_command(mst_pkg::OP_DATA, 8'hFF);
        send_command(mst_pkg::OP_DATA, 8'h00);
        send_command(mst_pkg::OP_STOP, 8'hFF);
        send_command(OP_UNUSED, 8'hFF);
        send_command(OP_UNUSED, 8'h00);
        send_command(mst_pkg::OP_START, 8'h00);
        send_command(mst_pkg::OP_STOP, 8'h00);
        send_command(mst_pkg::OP_DATA, 8'h01);
        send_command(mst_pkg::OP_DATA, 8'h80);
        send_command(mst_pkg::OP_DATA, 8'h55);
        send_command(mst_pkg::OP_DATA, 8'hAA);
        send_command(mst_pkg::OP_STOP, 8'h00);
    endtask

    task automatic test_register_extremes();
        settle();
        write_all_timing('0);
        send_command(mst_pkg::OP_START, 8'h00);
        send_command(mst_pkg::OP_DATA, 8'h5A);
        send_command(mst_pkg::OP_STOP, 8'h00);
        settle();
        write_all_timing('1);
        send_command(mst_pkg::OP_START, 8'h00);
        send_command(mst_pkg::OP_DATA, 8'hC3);
        send_command(mst_pkg::OP_STOP, 8'h00);
    endtask

    task automatic test_random_traffic();
        repeat (4)
        begin
            settle();
            for (int i = 0; i < mst_pkg::NumRegs; i++)
                write_timing(mst_pkg::CfgIdxW'(i), pick_units());
            random_settings++;
            send_random_traffic(32);
        end
    endtask

    task automatic test_unstalled_run();
        settle();
        for (int i = 0; i < mst_pkg::NumRegs; i++)
            write_timing(mst_pkg::CfgIdxW'(i), pick_units());
        random_settings++;
        quiet = 1'b1;
        @(posedge clk);
        send_random_traffic(40);
    endtask

    initial
    begin
        timing_regs[mst_pkg::REG_MARK]      = 16'd50;
        timing_regs[mst_pkg::REG_SPACE]     = 16'd110;
        timing_regs[mst_pkg::REG_PAD]       = 16'd100;
        timing_regs[mst_pkg::REG_PRE]       = 16'd66;
        timing_regs[mst_pkg::REG_SYNC_HIGH] = 16'd2000;
        timing_regs[mst_pkg::REG_SYNC_GAP]  = 16'd400;
        timing_regs[mst_pkg::REG_TAIL_LOW]  = 16'd120;
        timing_regs[mst_pkg::REG_TAIL_HIGH] = 16'd60;
        line_now = 1'b0;
        foreach (cmd_count[i])
            cmd_count[i] = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_timing();
        test_register_extremes();
        test_random_traffic();
        test_unstalled_run();

        settle();
        repeat (TailCycles) @(posedge clk);

        $display("Covered %0d start, %0d data, %0d stop, %0d unused commands; %0d segments checked",
                 cmd_count[mst_pkg::OP_START], cmd_count[mst_pkg::OP_DATA],
                 cmd_count[mst_pkg::OP_STOP], cmd_count[OP_UNUSED], segments_checked);
        $display("Timing: defaults, all zero, all max, %0d random sets; last phase unstalled",
                 random_settings);
        if (error_count == 0 && pending_segments.size() == 0)
            $display("manchester_segment_transmitter_top: match");
        else
            $display("manchester_segment_transmitter_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
